### rtl/core/md5_pkg.sv
// md5_pkg: shared types, constants and tables for the MD5 digest engine.
// Holds the microcode word format and program ROM used by md5_seq and the
// top level datapath. No dependencies.
package md5_pkg;

  localparam int unsigned UPC_W = 5;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] PAD_BYTE = 32'h00000080;

  localparam logic [3:0] LEN_LO_IDX = 4'd14;
  localparam logic [3:0] LEN_HI_IDX = 4'd15;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [4:0] LAST_WORD_PTR = 5'd15;

  // micro-op driving the datapath for one step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_PAD,
    OP_ZFILL,
    OP_LEN,
    OP_CLR,
    OP_INIT,
    OP_RND1,
    OP_RND2,
    OP_ACC,
    OP_EMIT
  } op_t;

  // jump condition evaluated by the sequencer
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_FULL,
    COND_PTR_MORE,
    COND_RND_MORE,
    COND_FIN_MODE,
    COND_MID_MODE,
    COND_FIN_PEND
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic             wait_go;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic go;
    logic full;
    logic ptr_more;
    logic rnd_more;
    logic fin_mode;
    logic mid_mode;
    logic fin_pend;
  } seq_sts_t;

  // program addresses
  localparam logic [UPC_W-1:0] UPC_IDLE   = 5'd0;
  localparam logic [UPC_W-1:0] UPC_PAD    = 5'd1;
  localparam logic [UPC_W-1:0] UPC_ZFILL1 = 5'd2;
  localparam logic [UPC_W-1:0] UPC_SPLIT  = 5'd3;
  localparam logic [UPC_W-1:0] UPC_LEN    = 5'd4;
  localparam logic [UPC_W-1:0] UPC_CLR    = 5'd5;
  localparam logic [UPC_W-1:0] UPC_ZFILL2 = 5'd6;
  localparam logic [UPC_W-1:0] UPC_TOLEN  = 5'd7;
  localparam logic [UPC_W-1:0] UPC_COMP   = 5'd8;
  localparam logic [UPC_W-1:0] UPC_RND1   = 5'd9;
  localparam logic [UPC_W-1:0] UPC_RND2   = 5'd10;
  localparam logic [UPC_W-1:0] UPC_ACC    = 5'd11;
  localparam logic [UPC_W-1:0] UPC_MIDCHK = 5'd12;
  localparam logic [UPC_W-1:0] UPC_FINCHK = 5'd13;
  localparam logic [UPC_W-1:0] UPC_BACK   = 5'd14;
  localparam logic [UPC_W-1:0] UPC_EMIT   = 5'd16;

  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, wait_go: 1'b0, target: UPC_IDLE};
    case (pc)
      UPC_IDLE:   w = '{op: OP_IDLE,  cond: COND_FULL,     wait_go: 1'b1, target: UPC_COMP};
      UPC_PAD:    w = '{op: OP_PAD,   cond: COND_ALWAYS,   wait_go: 1'b0, target: UPC_ZFILL1};
      UPC_ZFILL1: w = '{op: OP_ZFILL, cond: COND_PTR_MORE, wait_go: 1'b0, target: UPC_ZFILL1};
      UPC_SPLIT:  w = '{op: OP_NOP,   cond: COND_MID_MODE, wait_go: 1'b0, target: UPC_COMP};
      UPC_LEN:    w = '{op: OP_LEN,   cond: COND_ALWAYS,   wait_go: 1'b0, target: UPC_COMP};
      UPC_CLR:    w = '{op: OP_CLR,   cond: COND_ALWAYS,   wait_go: 1'b0, target: UPC_ZFILL2};
      UPC_ZFILL2: w = '{op: OP_ZFILL, cond: COND_PTR_MORE, wait_go: 1'b0, target: UPC_ZFILL2};
      UPC_TOLEN:  w = '{op: OP_NOP,   cond: COND_ALWAYS,   wait_go: 1'b0, target: UPC_LEN};
      UPC_COMP:   w = '{op: OP_INIT,  cond: COND_ALWAYS,   wait_go: 1'b0, target: UPC_RND1};
      UPC_RND1:   w = '{op: OP_RND1,  cond: COND_ALWAYS,   wait_go: 1'b0, target: UPC_RND2};
      UPC_RND2:   w = '{op: OP_RND2,  cond: COND_RND_MORE, wait_go: 1'b0, target: UPC_RND1};
      UPC_ACC:    w = '{op: OP_ACC,   cond: COND_FIN_MODE, wait_go: 1'b0, target: UPC_EMIT};
      UPC_MIDCHK: w = '{op: OP_NOP,   cond: COND_MID_MODE, wait_go: 1'b0, target: UPC_CLR};
      UPC_FINCHK: w = '{op: OP_NOP,   cond: COND_FIN_PEND, wait_go: 1'b0, target: UPC_PAD};
      UPC_BACK:   w = '{op: OP_NOP,   cond: COND_ALWAYS,   wait_go: 1'b0, target: UPC_IDLE};
      UPC_EMIT:   w = '{op: OP_EMIT,  cond: COND_ALWAYS,   wait_go: 1'b1, target: UPC_IDLE};
      default:    w = '{op: OP_NOP,   cond: COND_ALWAYS,   wait_go: 1'b0, target: UPC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] shift_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
      4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
      4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
      4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word used by round r, all arithmetic mod 16
  function automatic logic [3:0] word_index(input logic [5:0] r);
    logic [3:0] x;
    logic [3:0] g;
    x = r[3:0];
    case (r[5:4])
      2'd0:    g = x;
      2'd1:    g = (x << 2) + x + 4'd1;
      2'd2:    g = (x << 1) + x + 4'd5;
      default: g = (x << 3) - x;
    endcase
    return g;
  endfunction

endpackage

### rtl/core/md5_seq.sv
// md5_seq: microcode sequencer for the MD5 engine: step counter, program
// ROM and conditional jumps. Uses md5_pkg for the word format and ROM.
module md5_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  md5_pkg::seq_sts_t sts_i,
  output md5_pkg::uword_t  uw_o
);

  logic [md5_pkg::UPC_W-1:0] pc_r;
  logic [md5_pkg::UPC_W-1:0] pc_nxt;
  md5_pkg::uword_t           uw;
  logic                      hit;

  assign uw   = md5_pkg::ucode(pc_r);
  assign uw_o = uw;

  always_comb begin
    unique case (uw.cond)
      md5_pkg::COND_ALWAYS:   hit = 1'b1;
      md5_pkg::COND_FULL:     hit = sts_i.full;
      md5_pkg::COND_PTR_MORE: hit = sts_i.ptr_more;
      md5_pkg::COND_RND_MORE: hit = sts_i.rnd_more;
      md5_pkg::COND_FIN_MODE: hit = sts_i.fin_mode;
      md5_pkg::COND_MID_MODE: hit = sts_i.mid_mode;
      md5_pkg::COND_FIN_PEND: hit = sts_i.fin_pend;
      default:                hit = 1'b0;
    endcase
  end

  always_comb begin
    if (uw.wait_go && !sts_i.go) begin
      pc_nxt = pc_r;
    end else if (hit) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= md5_pkg::UPC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### rtl/core/md5_digest_engine.sv
// md5_digest_engine: top level of the MD5 engine; byte gathering, padding,
// round datapath and digest output. Uses md5_pkg and md5_seq.
//
// Usage: the message arrives one byte per input transaction (in_data_byte
// valid when in_has_byte is set). in_last closes the message; the 0x80 byte,
// zero fill and 64-bit bit length are added and the digest is returned as
// one output transaction of four chaining words (out_digest_a..d). A
// transaction with in_last set and in_has_byte clear closes the message
// without a byte, so the empty message works.
// A byte that does not fill a block is taken without a stall. A
// byte that fills the 64-byte block stalls the input for the compression:
// 64 rounds, each as an RND1 and an RND2 step of the single round datapath,
// plus 5 control steps. Closing the message adds the pad step, the zero
// fill, one or two compressions and the digest load before out_valid.
// The digest sits in an output register; while the receiver stalls it holds,
// and the engine keeps taking bytes until the next digest is ready. That
// digest then waits in the emit step with the input stalled.
// Reset (rst_n low, synchronous) restores the initial chaining words, clears
// the byte count and drops out_valid.
module md5_digest_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_a,
  output logic [31:0] out_digest_b,
  output logic [31:0] out_digest_c,
  output logic [31:0] out_digest_d
);

  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_MID,
    MODE_FIN
  } mode_t;

  md5_pkg::uword_t   uw;
  md5_pkg::seq_sts_t sts;

  logic [31:0] blk_r [16];
  logic [31:0] ch_r  [4];
  logic [31:0] ch_nxt[4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] tmp_r, tmp_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [4:0]  ptr_r, ptr_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  mode_t       mode_r, mode_nxt;
  logic        fin_pend_r, fin_pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] dig_a_r, dig_b_r, dig_c_r, dig_d_r;
  logic [31:0] dig_a_nxt, dig_b_nxt, dig_c_nxt, dig_d_nxt;

  logic        in_acc;
  logic        out_free;
  logic [5:0]  pos;
  logic [4:0]  lane_sh;
  logic [31:0] byte_word;
  logic [31:0] keep_mask;
  logic [31:0] pad_word;
  logic [63:0] bit_len;
  logic [31:0] m_word;
  logic [31:0] f_val;
  logic [31:0] rot_in;
  logic [63:0] rot_wide;
  logic [31:0] new_b;

  md5_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts_i (sts),
    .uw_o  (uw)
  );

  assign in_stall  = (uw.op != md5_pkg::OP_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_digest_a = dig_a_r;
  assign out_digest_b = dig_b_r;
  assign out_digest_c = dig_c_r;
  assign out_digest_d = dig_d_r;

  assign pos     = cnt_r[5:0];
  assign lane_sh = {pos[1:0], 3'b000};
  assign bit_len = {cnt_r, 3'b000};

  // byte lane insert for the incoming data byte
  assign byte_word = (blk_r[pos[5:2]] & ~(32'h000000ff << lane_sh))
                   | ({24'b0, in_data_byte} << lane_sh);

  always_comb begin
    case (pos[1:0])
      2'd0:    keep_mask = 32'h00000000;
      2'd1:    keep_mask = 32'h000000ff;
      2'd2:    keep_mask = 32'h0000ffff;
      default: keep_mask = 32'h00ffffff;
    endcase
  end

  assign pad_word = (blk_r[pos[5:2]] & keep_mask) | (md5_pkg::PAD_BYTE << lane_sh);

  assign m_word = blk_r[md5_pkg::word_index(rnd_r)];

  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
  end

  assign rot_in   = tmp_r + f_val;
  assign rot_wide = {rot_in, rot_in} << md5_pkg::shift_amt(rnd_r);
  assign new_b    = b_r + rot_wide[63:32];

  always_comb begin
    sts.go       = (uw.op == md5_pkg::OP_IDLE)
                 ? (in_acc && ((in_has_byte && pos == md5_pkg::LAST_POS) || in_last))
                 : out_free;
    sts.full     = in_has_byte && (pos == md5_pkg::LAST_POS);
    sts.ptr_more = ptr_r < md5_pkg::LAST_WORD_PTR;
    sts.rnd_more = rnd_r != md5_pkg::LAST_ROUND;
    sts.fin_mode = (mode_r == MODE_FIN);
    sts.mid_mode = (mode_r == MODE_MID);
    sts.fin_pend = fin_pend_r;
  end

  always_comb begin
    ch_nxt       = ch_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    c_nxt        = c_r;
    d_nxt        = d_r;
    tmp_nxt      = tmp_r;
    rnd_nxt      = rnd_r;
    ptr_nxt      = ptr_r;
    cnt_nxt      = cnt_r;
    mode_nxt     = mode_r;
    fin_pend_nxt = fin_pend_r;
    dig_a_nxt    = dig_a_r;
    dig_b_nxt    = dig_b_r;
    dig_c_nxt    = dig_c_r;
    dig_d_nxt    = dig_d_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (uw.op)
      md5_pkg::OP_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            cnt_nxt = cnt_r + 61'd1;
          end
          fin_pend_nxt = in_last;
        end
      end
      md5_pkg::OP_PAD: begin
        ptr_nxt  = {1'b0, pos[5:2]} + 5'd1;
        // no room for the length in this block: it goes in a second one
        mode_nxt = (pos[5:3] == 3'b111) ? MODE_MID : MODE_FIN;
      end
      md5_pkg::OP_ZFILL: begin
        ptr_nxt = ptr_r + 5'd1;
      end
      md5_pkg::OP_CLR: begin
        ptr_nxt  = '0;
        mode_nxt = MODE_FIN;
      end
      md5_pkg::OP_INIT: begin
        a_nxt   = ch_r[0];
        b_nxt   = ch_r[1];
        c_nxt   = ch_r[2];
        d_nxt   = ch_r[3];
        rnd_nxt = '0;
      end
      md5_pkg::OP_RND1: begin
        tmp_nxt = a_r + md5_pkg::round_const(rnd_r) + m_word;
      end
      md5_pkg::OP_RND2: begin
        a_nxt   = d_r;
        d_nxt   = c_r;
        c_nxt   = b_r;
        b_nxt   = new_b;
        rnd_nxt = rnd_r + 6'd1;
      end
      md5_pkg::OP_ACC: begin
        ch_nxt[0] = ch_r[0] + a_r;
        ch_nxt[1] = ch_r[1] + b_r;
        ch_nxt[2] = ch_r[2] + c_r;
        ch_nxt[3] = ch_r[3] + d_r;
      end
      md5_pkg::OP_EMIT: begin
        if (out_free) begin
          dig_a_nxt     = ch_r[0];
          dig_b_nxt     = ch_r[1];
          dig_c_nxt     = ch_r[2];
          dig_d_nxt     = ch_r[3];
          out_valid_nxt = 1'b1;
          ch_nxt[0]     = md5_pkg::INIT_A;
          ch_nxt[1]     = md5_pkg::INIT_B;
          ch_nxt[2]     = md5_pkg::INIT_C;
          ch_nxt[3]     = md5_pkg::INIT_D;
          cnt_nxt       = '0;
          mode_nxt      = MODE_DATA;
          fin_pend_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r[0]     <= md5_pkg::INIT_A;
      ch_r[1]     <= md5_pkg::INIT_B;
      ch_r[2]     <= md5_pkg::INIT_C;
      ch_r[3]     <= md5_pkg::INIT_D;
      cnt_r       <= '0;
      mode_r      <= MODE_DATA;
      fin_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      rnd_r       <= '0;
    end else begin
      ch_r        <= ch_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      fin_pend_r  <= fin_pend_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      rnd_r       <= rnd_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    d_r     <= d_nxt;
    tmp_r   <= tmp_nxt;
    dig_a_r <= dig_a_nxt;
    dig_b_r <= dig_b_nxt;
    dig_c_r <= dig_c_nxt;
    dig_d_r <= dig_d_nxt;
  end

  // message block register file, one write per step, two in the length step
  always_ff @(posedge clk) begin
    case (uw.op)
      md5_pkg::OP_IDLE: begin
        if (in_acc && in_has_byte) begin
          blk_r[pos[5:2]] <= byte_word;
        end
      end
      md5_pkg::OP_PAD: begin
        blk_r[pos[5:2]] <= pad_word;
      end
      md5_pkg::OP_ZFILL: begin
        if (!ptr_r[4]) begin
          blk_r[ptr_r[3:0]] <= '0;
        end
      end
      md5_pkg::OP_LEN: begin
        blk_r[md5_pkg::LEN_LO_IDX] <= bit_len[31:0];
        blk_r[md5_pkg::LEN_HI_IDX] <= bit_len[63:32];
      end
      default: begin
      end
    endcase
  end

  // a pending close is only held while the program runs
  assert property (@(posedge clk) disable iff (!rst_n)
    fin_pend_r |-> (uw.op != md5_pkg::OP_IDLE))
    else $error("close pending while idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == md5_pkg::OP_EMIT && out_free) |=>
      (out_valid && cnt_r == '0 && ch_r[0] == md5_pkg::INIT_A && mode_r == MODE_DATA))
    else $error("digest load did not restart the chain");

  assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == md5_pkg::OP_RND2 && rnd_r == md5_pkg::LAST_ROUND) |=>
      (uw.op == md5_pkg::OP_ACC))
    else $error("round loop did not end after the last round");

  assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == md5_pkg::OP_ZFILL) |-> (ptr_r <= 5'd16))
    else $error("zero fill pointer out of range");

endmodule

### sim/md5_digest_engine_tb.sv
// md5_digest_engine_tb: self-checking testbench for md5_digest_engine.
// Streams messages byte by byte, predicts each MD5 digest and compares every
// output transaction. Needs md5_pkg and the engine RTL.
module md5_digest_engine_tb;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned ITEM_TARGET  = 650;
  localparam int unsigned STEADY_ITEMS = 80;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned DRAIN_CYCLES = 400;

  // round constants, round 0 in the top word
  localparam logic [64*32-1:0] ROUND_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, indexed by {round group, round mod 4}, first entry on top
  localparam logic [16*5-1:0] ROUND_S = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // word 0 is chaining word A
  typedef logic [3:0][31:0] digest_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_a;
  logic [31:0] out_digest_b;
  logic [31:0] out_digest_c;
  logic [31:0] out_digest_d;

  // predicted engine state
  logic [31:0] exp_chain [4];
  logic [31:0] exp_words [16];
  logic [60:0] exp_len;

  digest_t     digest_q [$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          idle_en;
  bit          hold_pending;

  md5_digest_engine i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_digest_a (out_digest_a),
    .out_digest_b (out_digest_b),
    .out_digest_c (out_digest_c),
    .out_digest_d (out_digest_d)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d digests outstanding", cycle_count,
             digest_q.size());
    $display("md5_digest_engine_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void load_initial_chain();
    exp_chain[0] = md5_pkg::INIT_A;
    exp_chain[1] = md5_pkg::INIT_B;
    exp_chain[2] = md5_pkg::INIT_C;
    exp_chain[3] = md5_pkg::INIT_D;
    exp_len = '0;
  endfunction

  function automatic void put_msg_byte(input logic [5:0] pos, input logic [7:0] v);
    exp_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] = v;
  endfunction

  function automatic void md5_compress_block();
    logic [31:0] a, b, c, d, f, t;
    logic [3:0]  g;
    logic [4:0]  s;
    int          r;
    a = exp_chain[0];
    b = exp_chain[1];
    c = exp_chain[2];
    d = exp_chain[3];
    for (r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = 4'(r);
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = 4'(5 * r + 1);
        end
        2: begin
          f = b ^ c ^ d;
          g = 4'(3 * r + 5);
        end
        default: begin
          f = c ^ (b | ~d);
          g = 4'(7 * r);
        end
      endcase
      t = a + f + ROUND_K[(63 - r) * 32 +: 32] + exp_words[g];
      s = ROUND_S[(15 - ((r / 16) * 4 + r % 4)) * 5 +: 5];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    exp_chain[0] += a;
    exp_chain[1] += b;
    exp_chain[2] += c;
    exp_chain[3] += d;
  endfunction

  // returns 1 when the transaction closes a message; dg then holds the digest
  function automatic bit predict_md5_item(input logic [7:0] data, input logic has_byte,
                                          input logic last, output digest_t dg);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    int          i;
    dg = '0;
    if (has_byte) begin
      pos = exp_len[5:0];
      put_msg_byte(pos, data);
      exp_len = exp_len + 1'b1;
      if (pos == 6'd63)
        md5_compress_block();
    end
    if (!last)
      return 1'b0;
    pos = exp_len[5:0];
    put_msg_byte(pos, 8'h80);
    for (i = int'(pos) + 1; i < 64; i++)
      put_msg_byte(i[5:0], 8'h00);
    // no room for the length: flush this block and pad a fresh one
    if (pos >= 6'd56) begin
      md5_compress_block();
      for (i = 0; i < 16; i++)
        exp_words[i] = '0;
    end
    bit_len = {exp_len, 3'b000};
    exp_words[14] = bit_len[31:0];
    exp_words[15] = bit_len[63:32];
    md5_compress_block();
    dg = {exp_chain[3], exp_chain[2], exp_chain[1], exp_chain[0]};
    load_initial_chain();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void report_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch at cycle %0d: %s expected %08h got %08h", cycle_count, what,
               want, got);
  endfunction

  always @(posedge clk) begin : check_digests
    digest_t want;
    digest_t got;
    int      i;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_digest_d, out_digest_c, out_digest_b, out_digest_a};
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest, word a", '0, got[0]);
      end else begin
        want = digest_q.pop_front();
        for (i = 0; i < 4; i++)
          if (want[i] !== got[i])
            report_mismatch($sformatf("digest word %0d", i), want[i], got[i]);
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_item(input logic [7:0] data, input logic has_byte, input logic last);
    digest_t dg;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_has_byte  <= has_byte;
    in_last      <= last;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (predict_md5_item(data, has_byte, last, dg))
      digest_q.push_back(dg);
    if (has_byte || last)
      items_sent++;
  endtask

  task automatic send_message(input int len, input bit close_with_byte, input int noise_pct);
    int k;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, close_with_byte && k == len - 1);
    end
    if (len == 0 || !close_with_byte)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain_digests();
    in_valid <= 1'b0;
    while (digest_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_item(8'hff, 1'b0, 1'b1);        // empty message, ignored byte all ones
    send_item(8'h00, 1'b0, 1'b0);        // idle transaction
    send_item(8'ha5, 1'b0, 1'b1);        // empty again right after a digest
    send_item(8'h00, 1'b1, 1'b1);        // single zero byte closed in one go
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);        // close without a byte
    send_item(8'h61, 1'b1, 1'b0);        // "abc"
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);        // idle inside a message
    send_item(8'h7f, 1'b1, 1'b0);
    send_item(8'h3c, 1'b1, 1'b1);
  endtask

  // lengths around the 56-byte length field and the 64-byte block edge
  task automatic test_pad_boundaries();
    int lens [6];
    int j;
    lens = '{55, 56, 57, 63, 64, 65};
    for (j = 0; j < 6; j++)
      send_message(lens[j], $urandom_range(0, 1) != 0, 0);
  endtask

  // receiver holds off while short messages keep coming, so the input backs up
  task automatic test_output_backpressure();
    int j;
    hold_pending = 1'b1;
    @(posedge clk);
    for (j = 0; j < 6; j++)
      send_message($urandom_range(0, 4), $urandom_range(0, 1) != 0, 10);
    drain_digests();
  endtask

  task automatic test_random_messages();
    int pick;
    int len;
    while (items_sent + STEADY_ITEMS < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0)
        idle_en = !idle_en;
      if ($urandom_range(0, 9) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      pick = $urandom_range(0, 9);
      if (pick < 5)
        len = $urandom_range(0, 20);
      else if (pick < 8)
        len = $urandom_range(50, 70);
      else
        len = $urandom_range(0, 140);
      send_message(len, $urandom_range(0, 2) != 0, $urandom_range(0, 15));
    end
  endtask

  task automatic test_steady_stream();
    int j;
    idle_en = 1'b0;
    for (j = 0; j < 4; j++)
      send_message($urandom_range(0, 40), $urandom_range(0, 1) != 0, 0);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_has_byte  <= 1'b0;
    in_last      <= 1'b0;
    fail_count        = 0;
    items_sent        = 0;
    idle_en           = 1'b1;
    hold_pending      = 1'b0;
    for (int i = 0; i < 16; i++)
      exp_words[i] = '0;
    load_initial_chain();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_pad_boundaries();
    test_output_backpressure();
    test_random_messages();
    test_steady_stream();

    drain_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digest_q.size() != 0) begin
      $display("%0d digests never arrived", digest_q.size());
      fail_count += digest_q.size();
    end
    if (fail_count == 0)
      $display("md5_digest_engine_tb: PASS");
    else
      $display("md5_digest_engine_tb: FAIL");
    $finish;
  end

endmodule
